// File: rtl/hbd_pkg.sv
// shared types and constants of the huffman byte decoder
package hbd_pkg;

  localparam int NodeCount         = 255;
  localparam int NodeBits          = 8;
  localparam int ChildBits         = 9;
  localparam int EntryBits         = 2 * ChildBits;
  localparam int CodeBits          = 8;
  localparam int CntBits           = $clog2(CodeBits);
  localparam int LengthFieldBits   = 24;
  localparam int LengthBitsDefault = 24;
  localparam int OpBits            = 2;
  localparam int SymBits           = 8;

  localparam logic [NodeBits-1:0] RootNode = NodeBits'(254);
  localparam logic [NodeBits-1:0] NullNode = NodeBits'(255);

  // input tdata layout, lowest bit up
  localparam int NodeIdxLsb   = 0;
  localparam int ChildZeroLsb = NodeIdxLsb + NodeBits;
  localparam int ChildOneLsb  = ChildZeroLsb + ChildBits;
  localparam int LengthLsb    = ChildOneLsb + ChildBits;
  localparam int CodeByteLsb  = LengthLsb + LengthFieldBits;
  localparam int InFieldBits  = CodeByteLsb + CodeBits;
  localparam int InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int OutDataBits  = ((SymBits + 7) / 8) * 8;

  typedef enum logic [OpBits-1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_START      = 2'd1,
    OP_CODE_BYTE  = 2'd2
  } op_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic node_wr;
    logic len_load;
    logic byte_load;
    logic rd_cur;
    logic rd_next;
    logic step;
    logic flush;
  } hbd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sym_zero;
    logic is_leaf;
    logic last_bit;
    logic done_hit;
    logic pend_valid;
    logic out_can_load;
  } hbd_stat_t;

endpackage

// File: rtl/huffman_byte_decoder.sv
// top level of the huffman byte decoder
//
// input stream (s_axis): one word per item, tuser selects the item kind
//   write node: stores both children of one tree node; the input stays ready
//   start: loads the symbol count and returns the walk to root node 254;
//     the input stays ready
//   code byte: walked lsb first, one tree step per bit; the input is busy
//     while it is walked (accept, table fetch, up to 8 bit steps, flush),
//     since every bit step needs the dependent read of the node table
// output stream (m_axis): one word per leaf reached; tlast marks the final
//   symbol of a byte, tuser flags the symbol that completes the count
// a decoded symbol is held back until the next leaf of the same byte or
//   the end of the byte shows whether it is the last one; it then moves
//   from the pending slot to the output register, at that next leaf or
//   in the flush state at the end of the byte
// a stalled receiver freezes the walk at a leaf while the output register
//   and the pending symbol are both occupied; nothing is dropped
// reset returns the walk to the root, clears the symbol count and empties
//   the output; the node table holds no reset value and must be written
//   before any node is used
module huffman_byte_decoder import hbd_pkg::*; #(
  parameter int LengthBits = LengthBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node_index, child_zero, child_one, length, code_byte, zero pad
  input  logic [InDataBits-1:0]  s_axis_tdata,
  // operation
  input  logic [OpBits-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // symbol
  output logic [OutDataBits-1:0] m_axis_tdata,
  // last_of_byte
  output logic                   m_axis_tlast,
  // chunk_done
  output logic                   m_axis_tuser
);

  hbd_cmd_t           cmd;
  hbd_stat_t          stat;
  logic [SymBits-1:0] symbol;

  // sequencer: one state per phase of a byte
  hbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // node table, walk registers, pending symbol and output register
  hbd_datapath #(
    .LengthBits (LengthBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .node_index_i (s_axis_tdata[ChildZeroLsb-1:NodeIdxLsb]),
    .child_zero_i (s_axis_tdata[ChildOneLsb-1:ChildZeroLsb]),
    .child_one_i  (s_axis_tdata[LengthLsb-1:ChildOneLsb]),
    .length_i     (s_axis_tdata[CodeByteLsb-1:LengthLsb]),
    .code_byte_i  (s_axis_tdata[InFieldBits-1:CodeByteLsb]),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_symbol_o (symbol),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = OutDataBits'(symbol);

  // the pending slot is always drained before new items are taken
  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.pend_valid)
    else $error("pending symbol left while accepting input");

  // the symbol that completes the count always closes its byte
  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("chunk completed on a symbol not marked last of byte");

  // a byte with no symbols left does not start a walk
  a_byte_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CODE_BYTE) && stat.sym_zero)
      |=> s_axis_tready)
    else $error("byte with zero count started a walk");

  // a table write never starts a walk
  a_write_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE_NODE))
      |=> (s_axis_tready && !cmd.step))
    else $error("node write left the input busy");

endmodule

// File: rtl/hbd_ctrl.sv
// controller state machine of the huffman byte decoder
module hbd_ctrl import hbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [OpBits-1:0]     in_op_i,
  input  hbd_stat_t             stat_i,
  output logic                  in_ready_o,
  output hbd_cmd_t              cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_STEP  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op;
  logic   stall;
  logic   byte_end;

  assign op       = op_e'(in_op_i);
  // a new symbol needs the pending slot, which needs the output register
  assign stall    = stat_i.is_leaf && stat_i.pend_valid && !stat_i.out_can_load;
  assign byte_end = stat_i.last_bit || (stat_i.is_leaf && stat_i.done_hit);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            OP_WRITE_NODE: cmd_o.node_wr = 1'b1;
            OP_START:      cmd_o.len_load = 1'b1;
            OP_CODE_BYTE: begin
              if (!stat_i.sym_zero) begin
                cmd_o.byte_load = 1'b1;
                state_d         = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_STEP;
      end
      ST_STEP: begin
        if (!stall) begin
          cmd_o.step = 1'b1;
          if (byte_end) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_can_load) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/hbd_datapath.sv
// node table, tree walk, symbol counter and output registers
module hbd_datapath import hbd_pkg::*; #(
  parameter int LengthBits = LengthBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hbd_cmd_t                   cmd_i,
  input  logic [NodeBits-1:0]        node_index_i,
  input  logic [ChildBits-1:0]       child_zero_i,
  input  logic [ChildBits-1:0]       child_one_i,
  input  logic [LengthFieldBits-1:0] length_i,
  input  logic [CodeBits-1:0]        code_byte_i,
  input  logic                       out_ready_i,
  output hbd_stat_t                  stat_o,
  output logic                       out_valid_o,
  output logic [SymBits-1:0]         out_symbol_o,
  output logic                       out_last_o,
  output logic                       out_done_o
);

  logic [EntryBits-1:0]  mem_q [NodeCount];
  logic [EntryBits-1:0]  rdata_q;
  logic                  oob_q;

  logic [NodeBits-1:0]   cur_node_q;
  logic [LengthBits-1:0] sym_left_q;
  logic [CodeBits-1:0]   byte_q;
  logic [CntBits-1:0]    cnt_q;

  logic                  pend_valid_q;
  logic [SymBits-1:0]    pend_sym_q;
  logic                  pend_done_q;

  logic                  out_valid_q;
  logic [SymBits-1:0]    out_sym_q;
  logic                  out_last_q;
  logic                  out_done_q;

  logic [EntryBits-1:0]  entry;
  logic [ChildBits-1:0]  child;
  logic                  is_leaf;
  logic [NodeBits-1:0]   next_node;
  logic [NodeBits-1:0]   rd_addr;
  logic                  rd_en;
  logic                  done_hit;
  logic                  out_can_load;
  logic                  leaf_step;
  logic                  push_mid;

  // node 255 is outside the table and reads as two leaves of symbol zero
  assign entry     = oob_q ? '0 : rdata_q;
  assign child     = byte_q[0] ? entry[EntryBits-1:ChildBits] : entry[ChildBits-1:0];
  assign is_leaf   = !child[ChildBits-1];
  assign next_node = is_leaf ? RootNode : child[NodeBits-1:0];
  assign rd_addr   = cmd_i.rd_cur ? cur_node_q : next_node;
  assign rd_en     = cmd_i.rd_cur || cmd_i.rd_next;
  assign done_hit  = (sym_left_q == LengthBits'(1));

  assign out_can_load = !out_valid_q || out_ready_i;
  assign leaf_step    = cmd_i.step && is_leaf;
  assign push_mid     = leaf_step && pend_valid_q;

  assign stat_o.sym_zero     = (sym_left_q == '0);
  assign stat_o.is_leaf      = is_leaf;
  assign stat_o.last_bit     = (cnt_q == CntBits'(CodeBits - 1));
  assign stat_o.done_hit     = done_hit;
  assign stat_o.pend_valid   = pend_valid_q;
  assign stat_o.out_can_load = out_can_load;

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.node_wr && (node_index_i != NullNode)) begin
      mem_q[node_index_i] <= {child_one_i, child_zero_i};
    end
    if (rd_en) begin
      oob_q <= (rd_addr == NullNode);
      if (rd_addr != NullNode) begin
        rdata_q <= mem_q[rd_addr];
      end
    end
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_node_q   <= RootNode;
      sym_left_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.len_load) begin
        sym_left_q <= LengthBits'(length_i);
        cur_node_q <= RootNode;
      end
      if (cmd_i.step) begin
        cur_node_q <= next_node;
      end
      if (leaf_step) begin
        sym_left_q   <= sym_left_q - LengthBits'(1);
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push_mid || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_load) begin
      byte_q <= code_byte_i;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      byte_q <= byte_q >> 1;
      cnt_q  <= cnt_q + CntBits'(1);
    end
    if (leaf_step) begin
      pend_sym_q  <= child[SymBits-1:0];
      pend_done_q <= done_hit;
    end
    if (push_mid || cmd_i.flush) begin
      out_sym_q  <= pend_sym_q;
      out_done_q <= pend_done_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;
  assign out_done_o   = out_done_q;

endmodule

// File: test/hbd_checker.sv
// scoreboard for the huffman byte decoder: tree walk prediction and symbol compare
module hbd_checker import hbd_pkg::*; #(
  parameter int LengthBits = LengthBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [InDataBits-1:0]  s_tdata_i,
  input  logic [OpBits-1:0]      s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OutDataBits-1:0] m_tdata_i,
  input  logic                   m_tlast_i,
  input  logic                   m_tuser_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     symbols_o
);

  typedef struct packed {
    logic [SymBits-1:0] sym;
    logic               last;
    logic               done;
  } sym_word_t;

  logic [EntryBits-1:0]  tree_mem [NodeCount];
  logic [NodeBits-1:0]   walk_node;
  logic [LengthBits-1:0] symbols_left;
  sym_word_t             expected_syms [$];
  int                    fail_count = 0;
  int                    checked_syms = 0;

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [NodeBits-1:0]  idx;
    logic [CodeBits-1:0]  code;
    logic [EntryBits-1:0] entry;
    logic [ChildBits-1:0] child;
    sym_word_t            held;
    logic                 have_held;
    sym_word_t            want;
    int                   b;
    if (!rst_ni) begin
      walk_node    = RootNode;
      symbols_left = '0;
      expected_syms.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          OP_WRITE_NODE: begin
            idx = s_tdata_i[NodeIdxLsb +: NodeBits];
            if (idx != NullNode) begin
              tree_mem[idx] = {s_tdata_i[ChildOneLsb +: ChildBits],
                               s_tdata_i[ChildZeroLsb +: ChildBits]};
            end
          end
          OP_START: begin
            symbols_left = LengthBits'(s_tdata_i[LengthLsb +: LengthFieldBits]);
            walk_node    = RootNode;
          end
          OP_CODE_BYTE: begin
            code      = s_tdata_i[CodeByteLsb +: CodeBits];
            have_held = 1'b0;
            held      = '0;
            // lsb first, stops as soon as the count runs out
            for (b = 0; b < CodeBits && symbols_left != '0; b++) begin
              entry = (walk_node == NullNode) ? '0 : tree_mem[walk_node];
              child = code[b] ? entry[EntryBits-1:ChildBits] : entry[ChildBits-1:0];
              if (child[ChildBits-1]) begin
                walk_node = child[NodeBits-1:0];
              end else begin
                walk_node    = RootNode;
                symbols_left = symbols_left - LengthBits'(1);
                if (have_held) expected_syms.push_back(held);
                held      = '{sym: child[SymBits-1:0], last: 1'b0,
                              done: (symbols_left == '0)};
                have_held = 1'b1;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              expected_syms.push_back(held);
            end
          end
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        checked_syms++;
        if (expected_syms.size() == 0) begin
          note_failure($sformatf("unexpected symbol word: sym %02h last %0b done %0b",
                                 m_tdata_i, m_tlast_i, m_tuser_i));
        end else begin
          want = expected_syms.pop_front();
          if (m_tdata_i[SymBits-1:0] != want.sym || m_tlast_i != want.last ||
              m_tuser_i != want.done) begin
            note_failure($sformatf(
              "symbol mismatch: expected sym %02h last %0b done %0b, got sym %02h last %0b done %0b",
              want.sym, want.last, want.done, m_tdata_i, m_tlast_i, m_tuser_i));
          end
        end
      end
    end
    errors_o  <= fail_count;
    pending_o <= expected_syms.size();
    symbols_o <= checked_syms;
  end

endmodule

// File: test/tb_huffman_byte_decoder.sv
// testbench top for the huffman byte decoder: stimulus, flow control and verdict
module tb_huffman_byte_decoder;
  import hbd_pkg::*;

  // operation code the block ignores
  localparam logic [OpBits-1:0] OpUnused = 2'd3;
  localparam int ItemTarget = 460;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [OpBits-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  int   errors, pending, symbols;
  int   items_sent = 0;
  int   node_writes = 0, chunk_starts = 0, code_bytes = 0, noise_words = 0;
  int   burst_left = 0;
  logic hold_off;
  // nodes written so far; new pointers only go to these so no walk hits an empty node
  logic tree_ready [NodeCount];

  huffman_byte_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  hbd_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tlast_i (m_axis_tlast),
    .m_tuser_i (m_axis_tuser),
    .errors_o  (errors),
    .pending_o (pending),
    .symbols_o (symbols)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // timeout for a hung run; it allows for every word's busy time and gap and for
  // the symbols of each byte under the slow receiver, with a wide margin
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [InDataBits-1:0] pack_word(
    input logic [NodeBits-1:0]        idx,
    input logic [ChildBits-1:0]       c0,
    input logic [ChildBits-1:0]       c1,
    input logic [LengthFieldBits-1:0] len,
    input logic [CodeBits-1:0]        code
  );
    logic [InDataBits-1:0] w;
    w = '0;
    w[NodeIdxLsb +: NodeBits]          = idx;
    w[ChildZeroLsb +: ChildBits]       = c0;
    w[ChildOneLsb +: ChildBits]        = c1;
    w[LengthLsb +: LengthFieldBits]    = len;
    w[CodeByteLsb +: CodeBits]         = code;
    return w;
  endfunction

  // leaf, pointer to the null node, or pointer to a node already written
  function automatic logic [ChildBits-1:0] pick_child();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 45) return {1'b0, 8'($urandom)};
    if (r < 52) return '1;
    do n = $urandom_range(0, NodeCount - 1); while (!tree_ready[n]);
    return {1'b1, 8'(n)};
  endfunction

  // offer one word and hold it until taken; bursts with random gaps between
  task automatic send_word(input logic [OpBits-1:0] op, input logic [InDataBits-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  // unused fields of each word carry random bits
  task automatic put_node(input logic [NodeBits-1:0] idx, input logic [ChildBits-1:0] c0,
                          input logic [ChildBits-1:0] c1);
    send_word(OP_WRITE_NODE, pack_word(idx, c0, c1, 24'($urandom), 8'($urandom)));
    if (idx != NullNode) begin
      tree_ready[idx] = 1'b1;
      items_sent++;
    end
    node_writes++;
  endtask

  task automatic put_start(input logic [LengthFieldBits-1:0] len);
    send_word(OP_START, pack_word(8'($urandom), 9'($urandom), 9'($urandom), len,
                                  8'($urandom)));
    items_sent++;
    chunk_starts++;
  endtask

  task automatic put_byte(input logic [CodeBits-1:0] code);
    send_word(OP_CODE_BYTE, pack_word(8'($urandom), 9'($urandom), 9'($urandom),
                                      24'($urandom), code));
    items_sent++;
    code_bytes++;
  endtask

  task automatic put_noise();
    send_word(OpUnused, pack_word(8'($urandom), 9'($urandom), 9'($urandom),
                                  24'($urandom), 8'($urandom)));
    noise_words++;
  endtask

  // receiver: modes of always ready, coin flip, mostly stalled and a fixed on/off beat
  initial begin : receiver
    int   mode, span, beat;
    logic rdy;
    m_axis_tready = 1'b0;
    beat = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(posedge clk_i);
        beat++;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((beat % 5) < 3);
        endcase
        m_axis_tready <= rdy && !hold_off;
      end
    end
  end

  // one long receiver hold-off partway through, while words keep coming
  initial begin : long_stall
    int held;
    hold_off = 1'b0;
    while (items_sent < 180) @(posedge clk_i);
    hold_off <= 1'b1;
    for (held = 0; held < 400; held++) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    int   r;
    logic [LengthFieldBits-1:0] len;
    for (int i = 0; i < NodeCount; i++) tree_ready[i] = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE_NODE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: small tree with both leaf extremes, a pointer back to the root
    // and a pointer to the null node
    put_node(NullNode, '1, '1);                 // write to node 255 must be dropped
    put_node(8'd0, 9'd0, 9'd255);
    put_node(8'd1, 9'd510, 9'd511);
    put_node(RootNode, 9'd256, 9'd257);
    put_noise();
    put_byte(8'hFF);                            // no count loaded yet: ignored
    put_start('0);
    put_byte(8'h00);                            // zero length: ignored
    put_start(24'd3);
    put_byte(8'h00);                            // count runs out mid byte
    put_start('1);
    put_byte(8'hFF);                            // walk ends parked on the null node
    put_byte(8'h00);
    put_byte(8'hA5);
    put_byte(8'h5A);
    put_node(8'd0, 9'd257, 9'd128);
    put_byte(8'h3C);
    put_start(24'd1);
    put_byte(8'h55);
    put_byte(8'hAA);                            // count of one runs out in this byte
    put_start(24'd2);
    put_byte(8'hFF);

    // random chunks over a changing tree, with some noise mixed in
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 6))
          put_node(8'($urandom_range(0, 255)), pick_child(), pick_child());
      end
      r = $urandom_range(0, 99);
      if (r < 10)      len = 24'($urandom_range(0, 2));
      else if (r < 85) len = 24'($urandom_range(1, 24));
      else             len = 24'($urandom);
      put_start(len);
      repeat ($urandom_range(1, 10)) begin
        r = $urandom_range(0, 29);
        if (r == 0)      put_noise();
        else if (r < 3)  put_node(8'($urandom_range(0, 255)), pick_child(), pick_child());
        else             put_byte(8'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("sent %0d node writes, %0d chunk starts, %0d code bytes, %0d ignored words",
             node_writes, chunk_starts, code_bytes, noise_words);
    $display("checked %0d decoded symbols, %0d failures", symbols, errors);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
